>>> rtl/core/swr_pkg.sv
`default_nettype none

package swr_pkg;

  localparam int unsigned SWR_MAX_PAYLOAD_DEF = 512;
  localparam int unsigned SWR_QDEPTH = 2;
  localparam int unsigned SWR_QPTR_W = $clog2(SWR_QDEPTH);
  localparam int unsigned SWR_QCNT_W = $clog2(SWR_QDEPTH + 1);

  localparam logic [31:0] SWR_INIT_SEQ_RST = 32'd1000;
  localparam logic [31:0] SWR_MAGIC_RST = 32'hCAFE_BABE;
  localparam logic [9:0] SWR_HDR_BYTES = 10'd16;

  localparam logic [7:0] PT_SYN = 8'd0;
  localparam logic [7:0] PT_DATA = 8'd2;
  localparam logic [7:0] PT_FIN = 8'd4;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_OPEN = 2'd1;
  localparam logic [1:0] PH_CLOSED = 2'd2;

  typedef enum logic [2:0] {
    RT_NONE = 3'd0,
    RT_SYN_ACK = 3'd1,
    RT_ACK = 3'd3,
    RT_FIN_ACK = 3'd5
  } swr_reply_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_INVALID = 3'd1,
    ST_TYPE_IGN = 3'd2,
    ST_DUP_ACK = 3'd3,
    ST_HS_FAIL = 3'd4,
    ST_TIMEOUT = 3'd5,
    ST_CLOSED = 3'd6
  } swr_status_t;

  typedef enum logic [2:0] {
    K_TIMEOUT = 3'd0,
    K_INVALID = 3'd1,
    K_SYN = 3'd2,
    K_DATA = 3'd3,
    K_FIN = 3'd4,
    K_OTHER = 3'd5
  } swr_kind_t;

  typedef struct packed {
    swr_kind_t kind;
    logic [31:0] pkt_seq;
    logic [9:0] dlen;
  } swr_item_t;

  typedef struct packed {
    swr_status_t status;
    logic [1:0] phase;
    logic [9:0] deliver_len;
    logic deliver;
    logic [31:0] reply_ack;
    logic [31:0] reply_seq;
    swr_reply_t reply_type;
    logic reply_valid;
  } swr_result_t;

  localparam int unsigned SWR_RES_W = $bits(swr_result_t);
  localparam int unsigned SWR_OUT_W = ((SWR_RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> rtl/core/swr_front.sv
`default_nettype none

module swr_front
  import swr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = SWR_MAX_PAYLOAD_DEF
) (
  input  wire logic        is_timeout,
  input  wire logic [9:0]  pkt_len,
  input  wire logic [31:0] hdr_magic,
  input  wire logic [7:0]  pkt_type,
  input  wire logic [31:0] pkt_seq,
  input  wire logic [9:0]  payload_len,
  input  wire logic [31:0] magic_word,
  output swr_item_t        item
);

  logic pkt_ok;
  logic [9:0] dlen;

  assign pkt_ok = (pkt_len >= SWR_HDR_BYTES) && (hdr_magic == magic_word);

  always_comb begin
    if ({6'd0, payload_len} > 16'(MAX_PAYLOAD_BYTES)) begin
      dlen = 10'(MAX_PAYLOAD_BYTES);
    end else begin
      dlen = payload_len;
    end
  end

  always_comb begin
    item.pkt_seq = pkt_seq;
    item.dlen = dlen;
    priority if (is_timeout) begin
      item.kind = K_TIMEOUT;
    end else if (!pkt_ok) begin
      item.kind = K_INVALID;
    end else if (pkt_type == PT_SYN) begin
      item.kind = K_SYN;
    end else if (pkt_type == PT_DATA) begin
      item.kind = K_DATA;
    end else if (pkt_type == PT_FIN) begin
      item.kind = K_FIN;
    end else begin
      item.kind = K_OTHER;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/swr_queue.sv
`default_nettype none

module swr_queue
  import swr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire swr_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output swr_item_t      head
);

  swr_item_t entries [SWR_QDEPTH];
  logic [SWR_QPTR_W-1:0] wr_ptr;
  logic [SWR_QPTR_W-1:0] rd_ptr;
  logic [SWR_QCNT_W-1:0] count;

  assign full = (count == SWR_QCNT_W'(SWR_QDEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/swr_back.sv
`default_nettype none

module swr_back
  import swr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  input  wire swr_item_t   item,
  output logic             item_ready,
  input  wire logic [31:0] local_initial_seq,
  output logic             out_valid,
  input  wire logic        out_ready,
  output swr_result_t      result
);

  typedef enum logic [2:0] {
    S_WAIT = 3'b001,
    S_OPEN = 3'b010,
    S_CLOSED = 3'b100
  } sess_t;

  sess_t sess;
  sess_t sess_next;
  logic [31:0] expected_seq;
  logic [31:0] expected_seq_next;
  logic [31:0] local_seq;
  logic [31:0] local_seq_next;
  swr_result_t result_next;
  logic take;

  assign item_ready = !out_valid || out_ready;
  assign take = item_valid && item_ready;

  always_comb begin
    sess_next = sess;
    expected_seq_next = expected_seq;
    local_seq_next = local_seq;
    result_next = '0;
    result_next.reply_type = RT_NONE;
    result_next.status = ST_OK;
    unique case (sess)
      S_WAIT: begin
        if (item.kind == K_SYN) begin
          sess_next = S_OPEN;
          local_seq_next = local_initial_seq;
          expected_seq_next = item.pkt_seq + 32'd1;
          result_next.reply_valid = 1'b1;
          result_next.reply_type = RT_SYN_ACK;
          result_next.reply_seq = local_initial_seq;
          result_next.reply_ack = item.pkt_seq + 32'd1;
        end else begin
          sess_next = S_CLOSED;
          result_next.status = ST_HS_FAIL;
        end
      end
      S_OPEN: begin
        unique case (item.kind)
          K_TIMEOUT: begin
            sess_next = S_CLOSED;
            result_next.status = ST_TIMEOUT;
          end
          K_INVALID: begin
            result_next.status = ST_INVALID;
          end
          K_DATA: begin
            result_next.reply_valid = 1'b1;
            result_next.reply_type = RT_ACK;
            if (item.pkt_seq == expected_seq) begin
              expected_seq_next = expected_seq + 32'd1;
              local_seq_next = local_seq + 32'd1;
              result_next.reply_seq = local_seq + 32'd1;
              result_next.reply_ack = expected_seq + 32'd1;
              result_next.deliver = 1'b1;
              result_next.deliver_len = item.dlen;
            end else begin
              result_next.reply_seq = local_seq;
              result_next.reply_ack = expected_seq;
              result_next.status = ST_DUP_ACK;
            end
          end
          K_FIN: begin
            sess_next = S_CLOSED;
            local_seq_next = local_seq + 32'd1;
            result_next.reply_valid = 1'b1;
            result_next.reply_type = RT_FIN_ACK;
            result_next.reply_seq = local_seq + 32'd1;
            result_next.reply_ack = item.pkt_seq + 32'd1;
          end
          default: begin
            result_next.status = ST_TYPE_IGN;
          end
        endcase
      end
      default: begin
        result_next.status = ST_CLOSED;
      end
    endcase
    unique case (sess_next)
      S_WAIT: result_next.phase = PH_WAIT;
      S_OPEN: result_next.phase = PH_OPEN;
      default: result_next.phase = PH_CLOSED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sess <= S_WAIT;
      expected_seq <= '0;
      local_seq <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      sess <= sess_next;
      expected_seq <= expected_seq_next;
      local_seq <= local_seq_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stop_and_wait_receiver_top.sv
// Channel   Dir  Handshake                   Payload
// s_*       in   s_tvalid / s_tready         s_tdata packet header, s_tuser timeout flag
// m_*       out  m_tvalid / m_tready         m_tdata one result per transaction
// apb       in   psel & penable & pwrite     paddr, pwdata; prdata read back
//
// One transaction per cycle sustained while m_tready is high. An accepted transaction
// is written to the two-entry queue, then moved from its head to the output register;
// the session registers in the back end update with it, once per transaction.
// rst (synchronous) empties the queue, drops the output and returns to waiting for SYN.
// A stalled output holds its result; the queue absorbs up to two more transactions.
`default_nettype none

module stop_and_wait_receiver_top
  import swr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = SWR_MAX_PAYLOAD_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // pkt_len[9:0], hdr_magic[41:10], pkt_type[49:42], pkt_seq[81:50],
  // payload_len[91:82], zero[95:92]
  input  wire logic [95:0]          s_tdata,
  // is_timeout[0]
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // reply_valid[0], reply_type[3:1], reply_seq[35:4], reply_ack[67:36],
  // deliver[68], deliver_len[78:69], phase[80:79], status[83:81], zero[87:84]
  output logic [SWR_OUT_W-1:0]      m_tdata,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [31:0] local_initial_seq;
  logic [31:0] magic_word;
  swr_item_t fe_item;
  swr_item_t q_head;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic s_take;
  swr_result_t result;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? magic_word : local_initial_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_initial_seq <= SWR_INIT_SEQ_RST;
      magic_word <= SWR_MAGIC_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        magic_word <= pwdata;
      end else begin
        local_initial_seq <= pwdata;
      end
    end
  end

  assign s_tready = !q_full;
  assign s_take = s_tvalid && s_tready;

  swr_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .is_timeout (s_tuser),
    .pkt_len    (s_tdata[9:0]),
    .hdr_magic  (s_tdata[41:10]),
    .pkt_type   (s_tdata[49:42]),
    .pkt_seq    (s_tdata[81:50]),
    .payload_len(s_tdata[91:82]),
    .magic_word (magic_word),
    .item       (fe_item)
  );

  swr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_take),
    .push_item(fe_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  logic q_ready;
  assign q_pop = q_valid && q_ready;

  swr_back u_back (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (q_valid),
    .item             (q_head),
    .item_ready       (q_ready),
    .local_initial_seq(local_initial_seq),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .result           (result)
  );

  assign m_tdata = {(SWR_OUT_W - SWR_RES_W)'(0), result};

`ifndef SYNTHESIS
  a_deliver_is_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.deliver |->
      result.reply_type == RT_ACK && result.status == ST_OK && result.phase == PH_OPEN)
    else $error("delivery without in-order ACK");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !result.reply_valid |->
      result.reply_type == RT_NONE && result.reply_seq == '0 && result.reply_ack == '0)
    else $error("reply fields set without reply");

  a_fail_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (result.status == ST_HS_FAIL || result.status == ST_TIMEOUT) |->
      result.phase == PH_CLOSED)
    else $error("session not closed after failure");
`endif

endmodule

`default_nettype wire

>>> tb/sv/stop_and_wait_receiver_top_tb.sv
module stop_and_wait_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swr_pkg::*;

  localparam int unsigned CLK_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam logic [2:0] REG_INIT_SEQ = 3'd0;
  localparam logic [2:0] REG_MAGIC = 3'd4;
  localparam logic [7:0] PKT_SYN_ACK = 8'd1;
  localparam logic [7:0] PKT_ACK = 8'd3;
  localparam logic [7:0] PKT_FIN_ACK = 8'd5;
  localparam logic [7:0] PKT_UNKNOWN = 8'd6;
  localparam logic [7:0] PKT_MAX = 8'd255;

  typedef struct packed {
    logic        timeout;
    logic [9:0]  len;
    logic [31:0] magic;
    logic [7:0]  ptype;
    logic [31:0] seq;
    logic [9:0]  paylen;
  } rx_hdr_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // pkt_len[9:0], hdr_magic[41:10], pkt_type[49:42], pkt_seq[81:50],
  // payload_len[91:82], zero[95:92]
  logic [95:0]          s_tdata;
  // is_timeout[0]
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  // reply_valid[0], reply_type[3:1], reply_seq[35:4], reply_ack[67:36],
  // deliver[68], deliver_len[78:69], phase[80:79], status[83:81], zero[87:84]
  logic [SWR_OUT_W-1:0] m_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  logic [1:0]  sess_phase;
  logic [31:0] exp_seq;
  logic [31:0] loc_seq;
  logic [31:0] cfg_init_seq;
  logic [31:0] cfg_magic;

  swr_result_t reply_q[$];
  int unsigned err_cnt;
  int unsigned result_cnt;
  bit          src_idle;
  bit          sink_idle;
  bit          hold_req;

  stop_and_wait_receiver_top dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, result %0d: %s", $time, result_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic swr_result_t predict_reply(input rx_hdr_t h);
    swr_result_t r;
    logic        ok;
    r = '0;
    ok = !h.timeout && (h.len >= SWR_HDR_BYTES) && (h.magic == cfg_magic);
    case (sess_phase)
      PH_WAIT: begin
        if (ok && h.ptype == PT_SYN) begin
          loc_seq = cfg_init_seq;
          exp_seq = h.seq + 32'd1;
          sess_phase = PH_OPEN;
          r.reply_valid = 1'b1;
          r.reply_type = RT_SYN_ACK;
          r.reply_seq = loc_seq;
          r.reply_ack = exp_seq;
          r.status = ST_OK;
        end else begin
          sess_phase = PH_CLOSED;
          r.status = ST_HS_FAIL;
        end
      end
      PH_OPEN: begin
        if (h.timeout) begin
          sess_phase = PH_CLOSED;
          r.status = ST_TIMEOUT;
        end else if (!ok) begin
          r.status = ST_INVALID;
        end else if (h.ptype == PT_DATA) begin
          r.reply_valid = 1'b1;
          r.reply_type = RT_ACK;
          if (h.seq == exp_seq) begin
            exp_seq = exp_seq + 32'd1;
            loc_seq = loc_seq + 32'd1;
            r.deliver = 1'b1;
            r.deliver_len = (h.paylen > 10'(SWR_MAX_PAYLOAD_DEF)) ?
                            10'(SWR_MAX_PAYLOAD_DEF) : h.paylen;
            r.status = ST_OK;
          end else begin
            r.status = ST_DUP_ACK;
          end
          r.reply_seq = loc_seq;
          r.reply_ack = exp_seq;
        end else if (h.ptype == PT_FIN) begin
          loc_seq = loc_seq + 32'd1;
          sess_phase = PH_CLOSED;
          r.reply_valid = 1'b1;
          r.reply_type = RT_FIN_ACK;
          r.reply_seq = loc_seq;
          r.reply_ack = h.seq + 32'd1;
          r.status = ST_OK;
        end else begin
          r.status = ST_TYPE_IGN;
        end
      end
      default: r.status = ST_CLOSED;
    endcase
    r.phase = sess_phase;
    return r;
  endfunction

  function automatic rx_hdr_t make_hdr(input logic to, input logic [9:0] len,
                                       input logic [31:0] magic, input logic [7:0] ptype,
                                       input logic [31:0] seq, input logic [9:0] paylen);
    rx_hdr_t h;
    h.timeout = to;
    h.len = len;
    h.magic = magic;
    h.ptype = ptype;
    h.seq = seq;
    h.paylen = paylen;
    return h;
  endfunction

  function automatic rx_hdr_t data_hdr(input logic [31:0] seq, input logic [9:0] paylen);
    return make_hdr(1'b0, 10'($urandom_range(16, 528)), cfg_magic, PT_DATA, seq, paylen);
  endfunction

  function automatic rx_hdr_t random_traffic_hdr();
    rx_hdr_t     h;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    h = data_hdr(exp_seq, 10'($urandom_range(0, 512)));
    if (sel >= 70 && sel < 80) begin
      h.seq = $urandom_range(0, 1) ? exp_seq - 32'd1 : 32'($urandom);
    end else if (sel >= 80 && sel < 88) begin
      h.ptype = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) begin
        h.len = 10'($urandom_range(0, 15));
      end else begin
        h.magic = cfg_magic ^ (32'd1 << $urandom_range(0, 31));
      end
    end else if (sel >= 88) begin
      h.ptype = 8'($urandom_range(0, 255));
      if (h.ptype == PT_DATA || h.ptype == PT_FIN) begin
        h.ptype = PKT_ACK;
      end
      h.seq = $urandom;
    end
    return h;
  endfunction

  task automatic send_header(input rx_hdr_t h);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= h.timeout;
    s_tdata <= {4'b0, h.paylen, h.seq, h.ptype, h.magic, h.len};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reply_q.push_back(predict_reply(h));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == REG_INIT_SEQ) begin
      cfg_init_seq = data;
    end else if (addr == REG_MAGIC) begin
      cfg_magic = data;
    end
  endtask

  task automatic test_session_open();
    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_INIT_SEQ, 32'hFFFF_FFFF);
    send_header(make_hdr(1'b0, SWR_HDR_BYTES, cfg_magic, PT_SYN, 32'hFFFF_FFFF, 10'd0));
  endtask

  task automatic test_directed_packets();
    send_header(make_hdr(1'b0, SWR_HDR_BYTES, cfg_magic, PT_DATA, exp_seq, 10'd0));
    send_header(make_hdr(1'b0, 10'd528, cfg_magic, PT_DATA, exp_seq, 10'd512));
    send_header(data_hdr(exp_seq, 10'd1023));
    send_header(data_hdr(exp_seq, 10'd513));
    send_header(data_hdr(exp_seq + 32'd1, 10'd7));
    send_header(data_hdr(exp_seq - 32'd1, 10'd7));
    send_header(make_hdr(1'b0, 10'd15, cfg_magic, PT_DATA, exp_seq, 10'd3));
    send_header(make_hdr(1'b0, 10'd0, cfg_magic, PT_DATA, exp_seq, 10'd3));
    send_header(make_hdr(1'b0, 10'd64, 32'h0, PT_DATA, exp_seq, 10'd3));
    send_header(make_hdr(1'b0, 10'd64, 32'hFFFF_FFFE, PT_DATA, exp_seq, 10'd3));
    send_header(make_hdr(1'b0, 10'd64, cfg_magic, PT_SYN, exp_seq, 10'd0));
    send_header(make_hdr(1'b0, 10'd64, cfg_magic, PKT_SYN_ACK, exp_seq, 10'd0));
    send_header(make_hdr(1'b0, 10'd64, cfg_magic, PKT_ACK, exp_seq, 10'd0));
    send_header(make_hdr(1'b0, 10'd64, cfg_magic, PKT_FIN_ACK, exp_seq, 10'd0));
    send_header(make_hdr(1'b0, 10'd64, cfg_magic, PKT_UNKNOWN, exp_seq, 10'd0));
    send_header(make_hdr(1'b0, 10'd64, cfg_magic, PKT_MAX, exp_seq, 10'd0));
  endtask

  task automatic test_magic_update();
    wait_idle();
    write_reg(REG_MAGIC, 32'h0);
    write_reg(REG_INIT_SEQ, 32'h0);
    send_header(data_hdr(exp_seq, 10'd100));
    send_header(make_hdr(1'b0, 10'd64, 32'hFFFF_FFFF, PT_DATA, exp_seq, 10'd100));
    wait_idle();
    write_reg(REG_MAGIC, SWR_MAGIC_RST);
    send_header(data_hdr(exp_seq, 10'd200));
    send_header(make_hdr(1'b0, 10'd64, 32'h0, PT_DATA, exp_seq, 10'd200));
  endtask

  task automatic test_random_traffic();
    logic [31:0] magic_val;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        1: magic_val = 32'h0;
        2: magic_val = 32'hFFFF_FFFF;
        3: magic_val = SWR_MAGIC_RST;
        default: magic_val = $urandom;
      endcase
      write_reg(REG_MAGIC, magic_val);
      write_reg(REG_INIT_SEQ, $urandom);
      src_idle = (ph < 5) && (ph == 0 || $urandom_range(0, 1));
      sink_idle = (ph < 5) && (ph == 0 || $urandom_range(0, 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 100) begin
          hold_req = 1'b1;
        end
        send_header(random_traffic_hdr());
      end
    end
  endtask

  task automatic test_close();
    rx_hdr_t h;
    if ($urandom_range(0, 1)) begin
      send_header(make_hdr(1'b0, 10'd32, cfg_magic, PT_FIN, 32'($urandom), 10'd0));
    end else begin
      send_header(make_hdr(1'b1, 10'($urandom_range(0, 528)), 32'($urandom),
                           8'($urandom_range(0, 255)), 32'($urandom), 10'd0));
    end
    for (int i = 0; i < 24; i++) begin
      h = make_hdr(1'($urandom_range(0, 1)), 10'($urandom_range(0, 528)),
                   $urandom_range(0, 1) ? cfg_magic : 32'($urandom),
                   $urandom_range(0, 1) ? PT_SYN : 8'($urandom_range(0, 255)),
                   32'($urandom), 10'($urandom_range(0, 512)));
      send_header(h);
    end
  endtask

  initial begin
    int unsigned stall_left;
    swr_result_t got;
    swr_result_t want;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = swr_result_t'(m_tdata[SWR_RES_W-1:0]);
        if (reply_q.size() == 0) begin
          report_mismatch("result with no pending expectation");
        end else begin
          want = reply_q.pop_front();
          check_field("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
          check_field("reply_type", 32'(got.reply_type), 32'(want.reply_type));
          check_field("reply_seq", got.reply_seq, want.reply_seq);
          check_field("reply_ack", got.reply_ack, want.reply_ack);
          check_field("deliver", 32'(got.deliver), 32'(want.deliver));
          check_field("deliver_len", 32'(got.deliver_len), 32'(want.deliver_len));
          check_field("phase", 32'(got.phase), 32'(want.phase));
          check_field("status", 32'(got.status), 32'(want.status));
        end
        result_cnt++;
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall_left == 0 && sink_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CLK_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sess_phase = PH_WAIT;
    exp_seq = '0;
    loc_seq = '0;
    cfg_init_seq = SWR_INIT_SEQ_RST;
    cfg_magic = SWR_MAGIC_RST;
    err_cnt = 0;
    result_cnt = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_session_open();
    test_directed_packets();
    test_magic_update();
    test_random_traffic();
    test_close();
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
